// ===== rtl/core/pejts_pkg.sv =====
// types and constants shared by the job table scheduler
package pejts_pkg;
	localparam int unsigned SLOT_BITS = 3;
	localparam int unsigned STATE_BITS = 3;
	localparam int unsigned STATUS_BITS = 4;
	localparam logic [63:0] NO_DEADLINE = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		EV_SUBMIT = 3'd0,
		EV_DISPATCH = 3'd1,
		EV_COMPLETE = 3'd2,
		EV_BOUNDARY = 3'd3,
		EV_CANCEL = 3'd4,
		EV_COLLECT = 3'd5,
		EV_CANCEL_PIPE = 3'd6,
		EV_UNKNOWN = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		JS_FREE = 3'd0,
		JS_QUEUED = 3'd1,
		JS_RUNNING = 3'd2,
		JS_SUSPENDED = 3'd3,
		JS_DONE = 3'd4,
		JS_ERROR = 3'd5,
		JS_CANCELLED = 3'd6,
		JS_SPARE = 3'd7
	} job_state_t;

	typedef enum logic [3:0] {
		RS_OK = 4'd0,
		RS_FULL = 4'd1,
		RS_NOSLOT = 4'd2,
		RS_NOTFOUND = 4'd3,
		RS_BUSY = 4'd4,
		RS_ALREADY = 4'd5,
		RS_EMPTY = 4'd6,
		RS_ERROR = 4'd7,
		RS_CANCELLED = 4'd8
	} status_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [31:0] ident;
		logic [1:0]  pipeline;
		logic [7:0]  priority_lvl;
		logic [63:0] deadline_at;
		logic [31:0] order;
		logic [31:0] start;
		logic [31:0] span;
		logic        preemptible;
		logic [7:0]  fail;
	} slot_entry_t;
endpackage

// ===== rtl/core/priority_edf_job_table_scheduler.sv =====
// job table scheduler: one event per beat, table held in a slot memory
// steps per beat: running slot read, a scan that reads every slot and then
// drains the read port, fetch of the entry concerned, final write back
// the next event is taken once the last is through; a result waits in the output
// register while the next beat is taken, and the final step holds until it is taken
// arst_n clears slot states to free, ids to 1, sequence to 0, no job running.
module priority_edf_job_table_scheduler #(
	parameter int unsigned TABLE_SLOTS = 8,
	parameter int unsigned NUM_PIPELINES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mode[2:0] job_ident[34:3] pipeline_ident[36:35] priority_level[44:37]
	// deadline_span[76:45] may_preempt[77] now_time[140:78] run_ok[141]
	// fail_code[149:142] save_slot_free[150], zeros above
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[3:0] out_job_ident[35:4] out_slot[38:36] out_pipeline[40:39]
	// was_resumed[41] was_preempted[42] deadline_missed[43]
	// out_fail_code[51:44] cancel_count[55:52]
	output logic [55:0]  m_axis_tdata
);
	import pejts_pkg::*;

	localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_READ,
		SM_SCAN,
		SM_FIN_READ,
		SM_OUT,
		SM_FINISH
	} sm_t;

	// slot memory and slot states
	slot_entry_t mem [TABLE_SLOTS];
	slot_entry_t rd_q;
	job_state_t  st_q [TABLE_SLOTS];

	sm_t         sm_q;
	logic [3:0]  limit_q;
	logic [31:0] next_id_q;
	logic [31:0] next_ord_q;
	logic        run_vld_q;
	logic [IW-1:0] run_slot_q;

	// latched event fields
	event_t      ev_q;
	logic [31:0] id_q;
	logic [1:0]  pipe_q;
	logic [7:0]  prio_q;
	logic [31:0] span_q;
	logic        pre_q;
	logic [62:0] now_q;
	logic        ok_q;
	logic [7:0]  fcode_q;
	logic        save_q;

	// scan
	logic [CW-1:0] idx_q;
	logic [IW-1:0] rd_addr_q;
	logic [IW-1:0] scan_slot_s1;
	logic          scan_vld_s1;
	logic          hit_q;
	logic [IW-1:0] hit_slot_q;
	logic [7:0]    best_prio_q;
	logic [63:0]   best_dl_q;
	logic [31:0]   best_ord_q;
	logic          free_vld_q;
	logic [IW-1:0] free_slot_q;
	logic [CW-1:0] active_q;
	logic          outrank_q;
	logic [7:0]    run_prio_q;
	logic [3:0]    cnt_q;

	logic [55:0] out_q;
	logic [55:0] res_d;

	// combinational scan compare
	job_state_t  cur_st;
	logic        ahead;
	logic [63:0] dl_sum;
	logic [63:0] dl_new;
	logic [31:0] elapsed;
	logic [31:0] id_inc;
	logic        submit_ok;
	logic        fin_go;

	assign cur_st = st_q[scan_slot_s1];
	always_comb begin
		if (rd_q.priority_lvl != best_prio_q)
			ahead = rd_q.priority_lvl > best_prio_q;
		else if (rd_q.deadline_at != best_dl_q)
			ahead = rd_q.deadline_at < best_dl_q;
		else
			ahead = rd_q.order < best_ord_q;
	end

	assign dl_sum = {1'b0, now_q} + {32'd0, span_q};
	assign dl_new = (span_q == 32'd0 || dl_sum > NO_DEADLINE) ? NO_DEADLINE : dl_sum;
	assign elapsed = now_q[31:0] - rd_q.start;
	assign id_inc = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
	assign submit_ok = 32'(pipe_q) < NUM_PIPELINES && 32'(active_q) < 32'(limit_q) &&
		free_vld_q;

	// final step waits while an earlier result is still held
	assign fin_go = (sm_q == SM_FINISH) && (!m_axis_tvalid || m_axis_tready);

	assign s_axis_tready = (sm_q == SM_IDLE);
	assign m_axis_tdata = out_q;

	// slot memory: write port and registered read port
	slot_entry_t wr_data;
	logic        wr_en;
	logic [IW-1:0] wr_addr;
	always_comb begin
		wr_en = 1'b0;
		wr_addr = free_slot_q;
		wr_data = rd_q;
		if (fin_go) begin
			case (ev_q)
				EV_SUBMIT: begin
					wr_en = submit_ok;
					wr_data.ident = next_id_q;
					wr_data.pipeline = pipe_q;
					wr_data.priority_lvl = prio_q;
					wr_data.deadline_at = dl_new;
					wr_data.order = next_ord_q;
					wr_data.start = now_q[31:0];
					wr_data.span = span_q;
					wr_data.preemptible = pre_q;
					wr_data.fail = 8'd0;
				end
				EV_COMPLETE: begin
					wr_en = run_vld_q;
					wr_addr = run_slot_q;
					wr_data.fail = ok_q ? 8'd0 : fcode_q;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr_q];
	end

	// result word for the event in hand
	always_comb begin
		res_d = '0;
		case (ev_q)
			EV_SUBMIT: begin
				if (32'(pipe_q) >= NUM_PIPELINES)
					res_d[3:0] = RS_NOTFOUND;
				else if (32'(active_q) >= 32'(limit_q))
					res_d[3:0] = RS_FULL;
				else if (!free_vld_q)
					res_d[3:0] = RS_NOSLOT;
				else begin
					res_d[35:4] = next_id_q;
					res_d[38:36] = SLOT_BITS'(free_slot_q);
				end
			end
			EV_DISPATCH: begin
				if (run_vld_q) begin
					res_d[3:0] = RS_BUSY;
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(run_slot_q);
				end else if (!hit_q)
					res_d[3:0] = RS_EMPTY;
				else begin
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(hit_slot_q);
					res_d[40:39] = rd_q.pipeline;
					res_d[41] = st_q[hit_slot_q] == JS_SUSPENDED;
				end
			end
			EV_COMPLETE: begin
				if (!run_vld_q)
					res_d[3:0] = RS_EMPTY;
				else begin
					if (ok_q)
						res_d[3:0] = RS_OK;
					else
						res_d[3:0] = RS_ERROR;
					res_d[43] = rd_q.span != 32'd0 && elapsed > rd_q.span;
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(run_slot_q);
				end
			end
			EV_BOUNDARY: begin
				if (!run_vld_q)
					res_d[3:0] = RS_EMPTY;
				else begin
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(run_slot_q);
					res_d[42] = rd_q.preemptible && save_q && outrank_q;
				end
			end
			EV_CANCEL: begin
				if (!hit_q)
					res_d[3:0] = RS_NOTFOUND;
				else begin
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(hit_slot_q);
					case (st_q[hit_slot_q])
						JS_QUEUED, JS_SUSPENDED: res_d[3:0] = RS_OK;
						JS_RUNNING: res_d[3:0] = RS_BUSY;
						default: res_d[3:0] = RS_ALREADY;
					endcase
				end
			end
			EV_COLLECT: begin
				if (!hit_q)
					res_d[3:0] = RS_NOTFOUND;
				else begin
					res_d[35:4] = rd_q.ident;
					res_d[38:36] = SLOT_BITS'(hit_slot_q);
					case (st_q[hit_slot_q])
						JS_DONE: res_d[3:0] = RS_OK;
						JS_ERROR: begin
							res_d[3:0] = RS_ERROR;
							res_d[51:44] = rd_q.fail;
						end
						JS_CANCELLED: res_d[3:0] = RS_CANCELLED;
						default: res_d[3:0] = RS_BUSY;
					endcase
				end
			end
			EV_CANCEL_PIPE: begin
				if (32'(pipe_q) >= NUM_PIPELINES)
					res_d[3:0] = RS_NOTFOUND;
				else
					res_d[55:52] = cnt_q;
			end
			default: begin
				res_d[3:0] = RS_ERROR;
			end
		endcase
	end

	// sequencer, state table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_q <= SM_IDLE;
			limit_q <= 4'd8;
			next_id_q <= 32'd1;
			next_ord_q <= 32'd0;
			run_vld_q <= 1'b0;
			run_slot_q <= '0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < TABLE_SLOTS; i++)
				st_q[i] <= JS_FREE;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (fin_go)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			case (sm_q)
				SM_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						ev_q <= event_t'(s_axis_tdata[2:0]);
						id_q <= s_axis_tdata[34:3];
						pipe_q <= s_axis_tdata[36:35];
						prio_q <= s_axis_tdata[44:37];
						span_q <= s_axis_tdata[76:45];
						pre_q <= s_axis_tdata[77];
						now_q <= s_axis_tdata[140:78];
						ok_q <= s_axis_tdata[141];
						fcode_q <= s_axis_tdata[149:142];
						save_q <= s_axis_tdata[150];
						idx_q <= '0;
						rd_addr_q <= run_slot_q;
						scan_vld_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_vld_q <= 1'b0;
						active_q <= '0;
						outrank_q <= 1'b0;
						cnt_q <= 4'd0;
						sm_q <= SM_READ;
					end
				end
				SM_READ: begin
					// running slot entry arrives next cycle
					rd_addr_q <= '0;
					sm_q <= SM_SCAN;
				end
				SM_SCAN: begin
					if (!scan_vld_s1)
						run_prio_q <= rd_q.priority_lvl;
					// evaluate entry read last cycle
					if (scan_vld_s1) begin
						case (ev_q)
							EV_SUBMIT: begin
								if (cur_st == JS_QUEUED || cur_st == JS_RUNNING ||
									cur_st == JS_SUSPENDED)
									active_q <= active_q + CW'(1);
								if (cur_st == JS_FREE && !free_vld_q) begin
									free_vld_q <= 1'b1;
									free_slot_q <= scan_slot_s1;
								end
							end
							EV_DISPATCH: begin
								if ((cur_st == JS_QUEUED || cur_st == JS_SUSPENDED) &&
									(!hit_q || ahead)) begin
									hit_q <= 1'b1;
									hit_slot_q <= scan_slot_s1;
									best_prio_q <= rd_q.priority_lvl;
									best_dl_q <= rd_q.deadline_at;
									best_ord_q <= rd_q.order;
								end
							end
							EV_BOUNDARY: begin
								if (cur_st == JS_QUEUED && rd_q.priority_lvl > run_prio_q)
									outrank_q <= 1'b1;
							end
							EV_CANCEL, EV_COLLECT: begin
								if (!hit_q && id_q != 32'd0 && cur_st != JS_FREE &&
									rd_q.ident == id_q) begin
									hit_q <= 1'b1;
									hit_slot_q <= scan_slot_s1;
								end
							end
							EV_CANCEL_PIPE: begin
								if ((cur_st == JS_QUEUED || cur_st == JS_SUSPENDED) &&
									rd_q.pipeline == pipe_q && 32'(pipe_q) < NUM_PIPELINES) begin
									st_q[scan_slot_s1] <= JS_CANCELLED;
									if (cnt_q != 4'd15)
										cnt_q <= cnt_q + 4'd1;
								end
							end
							default: begin
							end
						endcase
					end
					if (idx_q == CW'(TABLE_SLOTS)) begin
						scan_vld_s1 <= 1'b0;
						sm_q <= SM_FIN_READ;
					end else begin
						scan_vld_s1 <= 1'b1;
						scan_slot_s1 <= idx_q[IW-1:0];
						rd_addr_q <= (idx_q == CW'(TABLE_SLOTS - 1)) ? idx_q[IW-1:0]
							: IW'(idx_q + CW'(1));
						idx_q <= idx_q + CW'(1);
					end
				end
				SM_FIN_READ: begin
					// fetch the entry the event concerns
					case (ev_q)
						EV_DISPATCH: rd_addr_q <= run_vld_q ? run_slot_q : hit_slot_q;
						EV_CANCEL, EV_COLLECT: rd_addr_q <= hit_slot_q;
						default: rd_addr_q <= run_slot_q;
					endcase
					sm_q <= SM_OUT;
				end
				SM_OUT: begin
					sm_q <= SM_FINISH;
				end
				SM_FINISH: begin
					if (fin_go) begin
						out_q <= res_d;
						sm_q <= SM_IDLE;
						case (ev_q)
							EV_SUBMIT: begin
								if (submit_ok) begin
									st_q[free_slot_q] <= JS_QUEUED;
									next_id_q <= id_inc;
									next_ord_q <= next_ord_q + 32'd1;
								end
							end
							EV_DISPATCH: begin
								if (!run_vld_q && hit_q) begin
									st_q[hit_slot_q] <= JS_RUNNING;
									run_vld_q <= 1'b1;
									run_slot_q <= hit_slot_q;
								end
							end
							EV_COMPLETE: begin
								if (run_vld_q) begin
									run_vld_q <= 1'b0;
									if (ok_q)
										st_q[run_slot_q] <= JS_DONE;
									else
										st_q[run_slot_q] <= JS_ERROR;
								end
							end
							EV_BOUNDARY: begin
								if (run_vld_q && rd_q.preemptible && save_q && outrank_q) begin
									st_q[run_slot_q] <= JS_SUSPENDED;
									run_vld_q <= 1'b0;
								end
							end
							EV_CANCEL: begin
								if (hit_q && (st_q[hit_slot_q] == JS_QUEUED ||
									st_q[hit_slot_q] == JS_SUSPENDED))
									st_q[hit_slot_q] <= JS_CANCELLED;
							end
							EV_COLLECT: begin
								if (hit_q && (st_q[hit_slot_q] == JS_DONE ||
									st_q[hit_slot_q] == JS_ERROR ||
									st_q[hit_slot_q] == JS_CANCELLED))
									st_q[hit_slot_q] <= JS_FREE;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					sm_q <= SM_IDLE;
				end
			endcase
		end
	end
endmodule
